// ----- rtl/grs_pkg.sv -----
package grs_pkg;

  // grid store size
  localparam int MAX_ROWS   = 64;
  localparam int MAX_COLS   = 64;
  localparam int CELL_COUNT = MAX_ROWS * MAX_COLS;

  // field and register widths
  localparam int CRD_W     = 6;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;

  // derived storage widths
  localparam int ROW_W   = $clog2(MAX_ROWS);
  localparam int COL_W   = $clog2(MAX_COLS);
  localparam int POS_W   = ROW_W + COL_W;
  localparam int SP_W    = $clog2(CELL_COUNT);
  localparam int DEPTH_W = SP_W + 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COLS = CFG_IDX_W'(1);

  // input opcodes
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // neighbor selection, in the order they are tried around a popped cell; NB_START picks the start cell
  typedef enum logic [2:0] {
    NB_RIGHT,
    NB_LEFT,
    NB_UP,
    NB_DOWN,
    NB_START
  } nb_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LD_RD,
    ST_LD_WR,
    ST_INIT,
    ST_NB_RD,
    ST_NB_EV,
    ST_POP_CHK,
    ST_POP_EV,
    ST_FIN
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic cap;
    logic ld_rd;
    logic ld_wr;
    logic s_init;
    logic nb_rd;
    logic nb_ev;
    logic nb_adv;
    logic pop_rd;
    logic pop_ev;
    logic res_ld;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic cand_inb;
    logic nb_last;
    logic stk_empty;
    logic pop_hit;
  } sts_t;

endpackage

// ----- rtl/grs_ctrl.sv -----
module grs_ctrl
  import grs_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic opcode_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          state_d   = (opcode_i == OP_SEARCH) ? ST_INIT : ST_LD_RD;
        end
      end
      ST_LD_RD: begin
        cmd_o.ld_rd = 1'b1;
        state_d     = ST_LD_WR;
      end
      ST_LD_WR: begin
        cmd_o.ld_wr = 1'b1;
        state_d     = ST_IDLE;
      end
      ST_INIT: begin
        cmd_o.s_init = 1'b1;
        state_d      = ST_NB_RD;
      end
      ST_NB_RD: begin
        if (sts_i.cand_inb) begin
          cmd_o.nb_rd = 1'b1;
          state_d     = ST_NB_EV;
        end else begin
          cmd_o.nb_adv = 1'b1;
          state_d      = sts_i.nb_last ? ST_POP_CHK : ST_NB_RD;
        end
      end
      ST_NB_EV: begin
        cmd_o.nb_ev  = 1'b1;
        cmd_o.nb_adv = 1'b1;
        state_d      = sts_i.nb_last ? ST_POP_CHK : ST_NB_RD;
      end
      ST_POP_CHK: begin
        if (sts_i.stk_empty) begin
          state_d = ST_FIN;
        end else begin
          cmd_o.pop_rd = 1'b1;
          state_d      = ST_POP_EV;
        end
      end
      ST_POP_EV: begin
        cmd_o.pop_ev = 1'b1;
        state_d      = sts_i.pop_hit ? ST_FIN : ST_NB_RD;
      end
      ST_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.res_ld = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.res_ld) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/grs_dpath.sv -----
module grs_dpath
  import grs_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic [CRD_W-1:0]     cell_x_i,
  input  logic [CRD_W-1:0]     cell_y_i,
  input  logic                 cell_blocked_i,
  input  logic [CRD_W-1:0]     start_x_i,
  input  logic [CRD_W-1:0]     start_y_i,
  input  logic [CRD_W-1:0]     goal_x_i,
  input  logic [CRD_W-1:0]     goal_y_i,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  output logic                 found_o
);

  // configuration
  logic [CFG_W-1:0] grid_rows_q, grid_cols_q;
  logic [CFG_W-1:0] rows_eff, cols_eff;

  // captured item
  logic [CRD_W-1:0] cell_x_q, cell_y_q, start_x_q, start_y_q, goal_x_q, goal_y_q;
  logic             cell_blocked_q;

  // search state
  nb_sel_e             nb_q;
  logic [ROW_W-1:0]    cur_r_q;
  logic [COL_W-1:0]    cur_c_q;
  logic [DEPTH_W-1:0]  depth_q;
  logic [DEPTH_W-1:0]  pop_addr;
  logic                found_q, res_q;

  // row stores, a clear row valid bit stands for a cleared row
  logic [MAX_COLS-1:0] grid_mem [MAX_ROWS];
  logic [MAX_COLS-1:0] vis_mem  [MAX_ROWS];
  logic [MAX_ROWS-1:0] grid_rv_q, vis_rv_q;
  logic [MAX_COLS-1:0] grid_rd_q, vis_rd_q;
  logic                grid_rdv_q, vis_rdv_q;
  logic [POS_W-1:0]    stack_mem [CELL_COUNT];
  logic [POS_W-1:0]    stack_rd_q;

  logic [CFG_W-1:0]    cand_r, cand_c;
  logic                cand_ok;
  logic [ROW_W-1:0]    rd_row, ld_row;
  logic [COL_W-1:0]    ld_col, nb_col;
  logic                ld_ok;
  logic [MAX_COLS-1:0] grid_base, grid_wdata, vis_base, vis_wdata;
  logic                take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_rows_q <= CFG_W'(64);
      grid_cols_q <= CFG_W'(64);
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_ROWS) begin
        grid_rows_q <= cfg_data_i;
      end else if (cfg_index_i == REG_COLS) begin
        grid_cols_q <= cfg_data_i;
      end
    end
  end

  assign rows_eff = (32'(grid_rows_q) > 32'(MAX_ROWS)) ? CFG_W'(MAX_ROWS) : grid_rows_q;
  assign cols_eff = (32'(grid_cols_q) > 32'(MAX_COLS)) ? CFG_W'(MAX_COLS) : grid_cols_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      cell_x_q       <= cell_x_i;
      cell_y_q       <= cell_y_i;
      cell_blocked_q <= cell_blocked_i;
      start_x_q      <= start_x_i;
      start_y_q      <= start_y_i;
      goal_x_q       <= goal_x_i;
      goal_y_q       <= goal_y_i;
    end
  end

  // candidate cell for the current neighbor slot
  always_comb begin
    cand_r  = CFG_W'(cur_r_q);
    cand_c  = CFG_W'(cur_c_q);
    cand_ok = 1'b1;
    case (nb_q)
      NB_RIGHT: cand_c = CFG_W'(cur_c_q) + CFG_W'(1);
      NB_LEFT: begin
        cand_c  = CFG_W'(cur_c_q) - CFG_W'(1);
        cand_ok = (cur_c_q != '0);
      end
      NB_UP: begin
        cand_r  = CFG_W'(cur_r_q) - CFG_W'(1);
        cand_ok = (cur_r_q != '0);
      end
      NB_DOWN: cand_r = CFG_W'(cur_r_q) + CFG_W'(1);
      NB_START: begin
        cand_r = CFG_W'(start_y_q);
        cand_c = CFG_W'(start_x_q);
      end
      default: cand_ok = 1'b0;
    endcase
  end

  assign sts_o.cand_inb  = cand_ok && (cand_r < rows_eff) && (cand_c < cols_eff);
  assign sts_o.nb_last   = (nb_q == NB_DOWN) || (nb_q == NB_START);
  assign sts_o.stk_empty = (depth_q == '0);
  assign sts_o.pop_hit   = (stack_rd_q == {ROW_W'(goal_y_q), COL_W'(goal_x_q)});

  assign ld_row = ROW_W'(cell_y_q);
  assign ld_col = COL_W'(cell_x_q);
  assign ld_ok  = (32'(cell_y_q) < 32'(MAX_ROWS)) && (32'(cell_x_q) < 32'(MAX_COLS));
  assign rd_row = cmd_i.ld_rd ? ld_row : cand_r[ROW_W-1:0];
  assign nb_col = cand_c[COL_W-1:0];

  // merge the single-cell update into the row just read
  always_comb begin
    grid_base          = grid_rdv_q ? grid_rd_q : '0;
    grid_wdata         = grid_base;
    grid_wdata[ld_col] = cell_blocked_q;
    vis_base           = vis_rdv_q ? vis_rd_q : '0;
    vis_wdata          = vis_base;
    vis_wdata[nb_col]  = 1'b1;
  end

  assign take = !grid_base[nb_col] && !vis_base[nb_col];

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_rd || cmd_i.nb_rd) begin
      grid_rd_q <= grid_mem[rd_row];
      vis_rd_q  <= vis_mem[rd_row];
    end
    if (cmd_i.ld_wr && ld_ok) begin
      grid_mem[ld_row] <= grid_wdata;
    end
    if (cmd_i.nb_ev && take) begin
      vis_mem[cand_r[ROW_W-1:0]] <= vis_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_rv_q  <= '0;
      vis_rv_q   <= '0;
      grid_rdv_q <= 1'b0;
      vis_rdv_q  <= 1'b0;
    end else begin
      if (cmd_i.ld_rd || cmd_i.nb_rd) begin
        grid_rdv_q <= grid_rv_q[rd_row];
        vis_rdv_q  <= vis_rv_q[rd_row];
      end
      if (cmd_i.ld_wr && ld_ok) begin
        grid_rv_q[ld_row] <= 1'b1;
      end
      if (cmd_i.s_init) begin
        vis_rv_q <= '0;
      end else if (cmd_i.nb_ev && take) begin
        vis_rv_q[cand_r[ROW_W-1:0]] <= 1'b1;
      end
    end
  end

  // pending stack
  assign pop_addr = depth_q - DEPTH_W'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.nb_ev && take && (depth_q < DEPTH_W'(CELL_COUNT))) begin
      stack_mem[depth_q[SP_W-1:0]] <= {cand_r[ROW_W-1:0], nb_col};
    end
    if (cmd_i.pop_rd) begin
      stack_rd_q <= stack_mem[pop_addr[SP_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
      nb_q    <= NB_START;
      found_q <= 1'b0;
    end else begin
      if (cmd_i.s_init) begin
        depth_q <= '0;
      end else if (cmd_i.nb_ev && take && (depth_q < DEPTH_W'(CELL_COUNT))) begin
        depth_q <= depth_q + DEPTH_W'(1);
      end else if (cmd_i.pop_rd) begin
        depth_q <= pop_addr;
      end
      if (cmd_i.s_init) begin
        nb_q <= NB_START;
      end else if (cmd_i.pop_ev) begin
        nb_q <= NB_RIGHT;
      end else if (cmd_i.nb_adv && !sts_o.nb_last) begin
        nb_q <= nb_sel_e'(nb_q + 3'd1);
      end
      if (cmd_i.s_init) begin
        found_q <= 1'b0;
      end else if (cmd_i.pop_ev && sts_o.pop_hit) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pop_ev) begin
      cur_r_q <= stack_rd_q[POS_W-1:COL_W];
      cur_c_q <= stack_rd_q[COL_W-1:0];
    end
    if (cmd_i.res_ld) begin
      res_q <= found_q;
    end
  end

  assign found_o = res_q;

endmodule

// ----- rtl/grid_reachability_search.sv -----
// grid reachability search: holds a 64 x 64 map of open and blocked cells and
// answers whether a goal cell can be reached from a start cell over
// four-neighbor steps through open cells inside the configured rows and
// columns. a load beat (opcode 0) writes one cell and gives no result; it
// is done as a read-modify-write of one grid row. a search beat
// (opcode 1) gives one found beat. the search is a depth-first walk run by
// a controller over one row-wide grid port, one row-wide visited port and
// a stack memory: each popped cell is read from the stack and checked, and each
// of its four neighbors is skipped when out of bounds or has its row read and
// checked otherwise; a search also waits on a stalled result. the grid and
// visited maps carry a valid bit per row, so reset clears both and the start
// of each search clears the visited map, at once with no sweep. grid_rows and
// grid_cols above 64 act as 64, 0 gives no cell in bounds.
// write the registers only while the block is idle. a finished result waits
// in an output register, so loads keep flowing while found is stalled.
module grid_reachability_search
  import grs_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  // input items
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 opcode_i,
  input  logic [CRD_W-1:0]     cell_x_i,
  input  logic [CRD_W-1:0]     cell_y_i,
  input  logic                 cell_blocked_i,
  input  logic [CRD_W-1:0]     start_x_i,
  input  logic [CRD_W-1:0]     start_y_i,
  input  logic [CRD_W-1:0]     goal_x_i,
  input  logic [CRD_W-1:0]     goal_y_i,
  // results
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 found_o
);

  cmd_t cmd;
  sts_t sts;

  // registers take a write beat in any cycle
  assign cfg_ready_o = 1'b1;

  // sequencing: accept, load row update, search walk, result hand-off
  grs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .opcode_i    (opcode_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // grid, visited map, stack and the result register
  grs_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .cell_x_i       (cell_x_i),
    .cell_y_i       (cell_y_i),
    .cell_blocked_i (cell_blocked_i),
    .start_x_i      (start_x_i),
    .start_y_i      (start_y_i),
    .goal_x_i       (goal_x_i),
    .goal_y_i       (goal_y_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .found_o        (found_o)
  );

`ifndef ASSERT_OFF
  // at most one memory or result step per cycle
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.ld_rd, cmd.ld_wr, cmd.nb_rd, cmd.nb_ev, cmd.pop_rd, cmd.pop_ev,
              cmd.res_ld}))
    else $error("more than one datapath step in a cycle");

  // a neighbor is judged only on the row read just before
  a_ev_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.nb_ev |-> $past(cmd.nb_rd))
    else $error("neighbor check without a row read");

  // never pop an empty stack
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.pop_rd |-> !sts.stk_empty)
    else $error("pop from an empty stack");

  // a result beat appears only after the result register was loaded
  a_res_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.res_ld))
    else $error("result valid without a finished search");
`endif

endmodule

// ----- bench/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import grs_pkg::*;

  // register indexes past the end of the list, writes there must do nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

  // long output hold-off that makes the block back up into its input
  localparam int unsigned HOLD_CYCLES = 400;
  // cycles to let a trailing load finish before a register write
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned PHASES = 6;
  localparam int unsigned BEATS_PER_PHASE = 130;

  typedef enum int unsigned {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_e;

  // one input beat, all fields together
  typedef struct packed {
    logic             opcode;
    logic [CRD_W-1:0] cell_x;
    logic [CRD_W-1:0] cell_y;
    logic             cell_blocked;
    logic [CRD_W-1:0] start_x;
    logic [CRD_W-1:0] start_y;
    logic [CRD_W-1:0] goal_x;
    logic [CRD_W-1:0] goal_y;
  } grid_beat_t;

  // shadow of the grid plus the queue of found flags still owed by the block
  class reach_scoreboard;
    bit          blocked_map [CELL_COUNT];
    bit          seen_map [CELL_COUNT];
    int unsigned walk_stack [$];
    bit          found_due [$];
    int unsigned rows_reg = MAX_ROWS;
    int unsigned cols_reg = MAX_COLS;
    int unsigned errors;
    int unsigned loads;
    int unsigned searches;
    int unsigned reachable_cnt;
    int unsigned unreachable_cnt;
    int unsigned reg_writes;

    function void set_bound(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      reg_writes++;
      if (idx == REG_ROWS) rows_reg = val;
      else if (idx == REG_COLS) cols_reg = val;
    endfunction

    function int unsigned pending();
      return found_due.size();
    endfunction

    // push a cell that is in bounds, open and not yet seen
    function void visit(int unsigned r, int unsigned c, int unsigned rows, int unsigned cols);
      int unsigned pos;
      if (r >= rows || c >= cols) return;
      pos = r * MAX_COLS + c;
      if (seen_map[pos] || blocked_map[pos]) return;
      seen_map[pos] = 1'b1;
      walk_stack.push_back(pos);
    endfunction

    // flood from the start cell, true once the goal is popped
    function bit reachable(int unsigned sx, int unsigned sy, int unsigned gx, int unsigned gy);
      int unsigned rows;
      int unsigned cols;
      int unsigned pos;
      int unsigned r;
      int unsigned c;
      rows = (rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg;
      cols = (cols_reg > MAX_COLS) ? MAX_COLS : cols_reg;
      foreach (seen_map[i]) seen_map[i] = 1'b0;
      walk_stack.delete();
      visit(sy, sx, rows, cols);
      while (walk_stack.size() != 0) begin
        pos = walk_stack.pop_back();
        r = pos / MAX_COLS;
        c = pos % MAX_COLS;
        if (r == gy && c == gx) return 1'b1;
        visit(r, c + 1, rows, cols);
        if (c > 0) visit(r, c - 1, rows, cols);
        if (r > 0) visit(r - 1, c, rows, cols);
        visit(r + 1, c, rows, cols);
      end
      return 1'b0;
    endfunction

    function void note_beat(grid_beat_t b);
      bit hit;
      if (b.opcode == OP_LOAD) begin
        loads++;
        blocked_map[b.cell_y * MAX_COLS + b.cell_x] = b.cell_blocked;
      end else begin
        searches++;
        hit = reachable(b.start_x, b.start_y, b.goal_x, b.goal_y);
        if (hit) reachable_cnt++;
        else unreachable_cnt++;
        found_due.push_back(hit);
      end
    endfunction

    function void check_found(logic got);
      bit want;
      if (found_due.size() == 0) begin
        errors++;
        $display("%0t: found beat with no search waiting, expected none actual %0d",
                 $time, got);
        return;
      end
      want = found_due.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t: found mismatch, expected %0d actual %0d", $time, want, got);
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]     cfg_data_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic                 opcode_i;
  logic [CRD_W-1:0]     cell_x_i;
  logic [CRD_W-1:0]     cell_y_i;
  logic                 cell_blocked_i;
  logic [CRD_W-1:0]     start_x_i;
  logic [CRD_W-1:0]     start_y_i;
  logic [CRD_W-1:0]     goal_x_i;
  logic [CRD_W-1:0]     goal_y_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic                 found_o;

  reach_scoreboard sb = new();
  idle_mode_e      idle_mode = IDLE_NONE;
  int unsigned     holds_asked = 0;

  // random phases: bounds and idle pattern for each
  int unsigned phase_rows [PHASES] = '{8, 10, 5, 12, 1, 16};
  int unsigned phase_cols [PHASES] = '{8, 6, 12, 12, 16, 3};
  idle_mode_e  phase_mode [PHASES] = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH,
                                       IDLE_NONE, IDLE_BOTH};

  grid_reachability_search DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .cell_x_i       (cell_x_i),
    .cell_y_i       (cell_y_i),
    .cell_blocked_i (cell_blocked_i),
    .start_x_i      (start_x_i),
    .start_y_i      (start_y_i),
    .goal_x_i       (goal_x_i),
    .goal_y_i       (goal_y_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .found_o        (found_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // idle chance in percent for the sending or the receiving side
  function automatic int unsigned idle_pct(bit recv_side);
    case (idle_mode)
      IDLE_SEND: return recv_side ? 0 : 65;
      IDLE_RECV: return recv_side ? 65 : 0;
      IDLE_BOTH: return 19;
      default:   return 0;
    endcase
  endfunction

  // drive one beat from a falling edge, hold it until taken, return on a falling edge
  task automatic send_beat(grid_beat_t b);
    while ($urandom_range(99) < idle_pct(1'b0)) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    opcode_i       = b.opcode;
    cell_x_i       = b.cell_x;
    cell_y_i       = b.cell_y;
    cell_blocked_i = b.cell_blocked;
    start_x_i      = b.start_x;
    start_y_i      = b.start_y;
    goal_x_i       = b.goal_x;
    goal_y_i       = b.goal_y;
    in_valid_i     = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_beat(b);
    @(negedge clk_i);
  endtask

  // load beat, search fields are don't-care noise
  task automatic send_load(int unsigned x, int unsigned y, bit blk);
    grid_beat_t b;
    b.opcode       = OP_LOAD;
    b.cell_x       = CRD_W'(x);
    b.cell_y       = CRD_W'(y);
    b.cell_blocked = blk;
    b.start_x      = CRD_W'($urandom_range(63));
    b.start_y      = CRD_W'($urandom_range(63));
    b.goal_x       = CRD_W'($urandom_range(63));
    b.goal_y       = CRD_W'($urandom_range(63));
    send_beat(b);
  endtask

  // search beat, cell fields are don't-care noise
  task automatic send_search(int unsigned sx, int unsigned sy, int unsigned gx,
                             int unsigned gy);
    grid_beat_t b;
    b.opcode       = OP_SEARCH;
    b.cell_x       = CRD_W'($urandom_range(63));
    b.cell_y       = CRD_W'($urandom_range(63));
    b.cell_blocked = 1'($urandom_range(1));
    b.start_x      = CRD_W'(sx);
    b.start_y      = CRD_W'(sy);
    b.goal_x       = CRD_W'(gx);
    b.goal_y       = CRD_W'(gy);
    send_beat(b);
  endtask

  // mostly loads and searches inside the bounds, some beats fully random
  function automatic grid_beat_t random_beat(int unsigned rows, int unsigned cols);
    grid_beat_t  b;
    int unsigned pick;
    b.opcode       = 1'($urandom_range(1));
    b.cell_x       = CRD_W'($urandom_range(63));
    b.cell_y       = CRD_W'($urandom_range(63));
    b.cell_blocked = 1'($urandom_range(1));
    b.start_x      = CRD_W'($urandom_range(63));
    b.start_y      = CRD_W'($urandom_range(63));
    b.goal_x       = CRD_W'($urandom_range(63));
    b.goal_y       = CRD_W'($urandom_range(63));
    pick = $urandom_range(99);
    if (pick < 55) begin
      // carve walls into the active area
      b.opcode       = OP_LOAD;
      b.cell_x       = CRD_W'($urandom_range(cols - 1));
      b.cell_y       = CRD_W'($urandom_range(rows - 1));
      b.cell_blocked = ($urandom_range(99) < 30);
    end else if (pick < 90) begin
      b.opcode  = OP_SEARCH;
      b.start_x = CRD_W'($urandom_range(cols - 1));
      b.start_y = CRD_W'($urandom_range(rows - 1));
      b.goal_x  = CRD_W'($urandom_range(cols - 1));
      b.goal_y  = CRD_W'($urandom_range(rows - 1));
    end
    return b;
  endfunction

  // drop valid, wait out every owed result, then let a trailing load retire
  task automatic settle();
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // register write from a falling edge, only while the block is idle
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    cfg_index_i = idx;
    cfg_data_i  = CFG_W'(val);
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_bound(idx, CFG_W'(val));
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // result side: random stall per idle mode, plus requested long hold-offs
  initial begin : drain_found
    int unsigned hold_left;
    int unsigned holds_served;
    hold_left    = 0;
    holds_served = 0;
    out_stall_i  = 1'b0;
    forever begin
      @(negedge clk_i);
      if (holds_asked != holds_served) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        out_stall_i = 1'b1;
        hold_left--;
      end else begin
        out_stall_i = ($urandom_range(99) < idle_pct(1'b1));
      end
    end
  end

  // a found beat moves on every rising edge with valid high and stall low
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_found(found_o);
  end

  // hard stop, far beyond the slowest legal run
  initial begin
    #40ms;
    $display("timeout with %0d found beats still owed", sb.pending());
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    int unsigned p;
    rst_ni         = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = '0;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    opcode_i       = OP_LOAD;
    cell_x_i       = '0;
    cell_y_i       = '0;
    cell_blocked_i = 1'b0;
    start_x_i      = '0;
    start_y_i      = '0;
    goal_x_i       = '0;
    goal_y_i       = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // full 64 x 64 map, all open after reset
    send_search(0, 0, 0, 0);      // start equals goal
    send_search(63, 63, 0, 0);    // far corner to origin
    send_load(63, 63, 1);
    send_search(0, 0, 63, 63);    // blocked goal, floods the whole map
    send_search(63, 63, 0, 0);    // blocked start
    settle();

    // bounds above the store size saturate, row 63 and column 62 stay reachable
    write_reg(REG_ROWS, 127);
    write_reg(REG_COLS, 100);
    send_search(0, 0, 62, 63);
    send_load(63, 63, 0);
    settle();

    // zero rows or zero columns leave nothing in bounds
    write_reg(REG_ROWS, 0);
    write_reg(REG_COLS, 64);
    send_search(0, 0, 0, 0);
    settle();
    write_reg(REG_ROWS, 64);
    write_reg(REG_COLS, 0);
    send_search(5, 5, 5, 5);
    settle();

    // single cell grid: goal or start just outside, blocked lone cell
    write_reg(REG_ROWS, 1);
    write_reg(REG_COLS, 1);
    send_search(0, 0, 0, 0);
    send_search(0, 0, 1, 0);
    send_search(0, 1, 0, 0);
    send_load(0, 0, 1);
    send_search(0, 0, 0, 0);
    send_load(0, 0, 0);
    settle();

    // 3 x 3 with a wall down the middle column, then a gap in it
    write_reg(REG_ROWS, 3);
    write_reg(REG_COLS, 3);
    write_reg(REG_SPARE_A, 127);
    write_reg(REG_SPARE_B, 0);
    send_load(1, 0, 1);
    send_load(1, 1, 1);
    send_load(1, 2, 1);
    send_search(0, 0, 2, 2);
    send_load(1, 1, 0);
    send_search(0, 0, 2, 2);
    send_search(0, 0, 1, 0);      // goal on the wall
    settle();

    // random phases over small bounds, each with its own idle pattern
    for (p = 0; p < PHASES; p++) begin
      idle_mode = phase_mode[p];
      write_reg(REG_ROWS, phase_rows[p]);
      write_reg(REG_COLS, phase_cols[p]);
      // back-pressure the result side while beats keep coming
      if (p == 0 || p == 3) holds_asked++;
      repeat (BEATS_PER_PHASE) send_beat(random_beat(phase_rows[p], phase_cols[p]));
      settle();
    end

    idle_mode = IDLE_NONE;
    repeat (50) @(negedge clk_i);
    if (sb.pending() != 0) begin
      sb.errors++;
      $display("%0t: %0d found beats never arrived", $time, sb.pending());
    end

    $display("covered %0d beats: %0d loads, %0d searches (%0d reachable, %0d not)",
             sb.loads + sb.searches, sb.loads, sb.searches, sb.reachable_cnt,
             sb.unreachable_cnt);
    $display("%0d register writes, bounds 0 to 127, four idle patterns, two long holds",
             sb.reg_writes);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
